// ===== hw/rtl/gpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gpf_pkg
// Widths, constants and shared types for the pairwise gravity force pipeline.
// ----------------------------------------------------------------------------
package gpf_pkg;

  // Field widths
  localparam int POS_BITS  = 24;
  localparam int MASS_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int G_W       = 32;
  localparam int OUT_W     = 48;

  // Derived arithmetic widths
  localparam int MAG_W   = POS_BITS;              // |delta| < 2^POS_BITS
  localparam int SQ_W    = 2 * MAG_W;
  localparam int S_W     = SQ_W + 2;              // sum of three squares
  localparam int ROOT_W  = MAG_W + 1;             // floor sqrt of s
  localparam int DSQ_W   = 2 * ROOT_W;
  localparam int CUBE_W  = 3 * ROOT_W;
  localparam int DEN_W   = CUBE_W + FRAC_BITS;
  localparam int MP_W    = 2 * MASS_BITS;
  localparam int GM_W    = G_W + MP_W;
  localparam int PIECE_W = 32;
  localparam int N_PIECE = (GM_W + PIECE_W - 1) / PIECE_W;
  localparam int PP_W    = PIECE_W + MAG_W;
  localparam int NUM_W   = GM_W + MAG_W;
  localparam int Q_W     = OUT_W + 1;
  localparam int DIV_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  // Configuration map
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_GRAV_COEFF = 3'd0;
  localparam logic [G_W-1:0]    GRAV_RESET     = 32'd1;

  // Saturation limits
  localparam logic [Q_W-1:0] POS_LIM = {2'b00, {(OUT_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIM = {2'b01, {(OUT_W-1){1'b0}}};

  // Side data carried through the root pipeline
  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0]            neg;
    logic                  zero;
  } root_tag_t;

  // Side data carried through the divider pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } div_tag_t;

endpackage

// ===== hw/rtl/gpf_root.sv =====
// ----------------------------------------------------------------------------
// gpf_root
// Pipelined floor square root, one result bit per stage, with running square.
// ----------------------------------------------------------------------------
module gpf_root
  import gpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [S_W-1:0]    in_s,
  input  root_tag_t         in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_d,
  output logic [DSQ_W-1:0]  out_dsq,
  output root_tag_t         out_tag
);

  logic              v_r   [ROOT_W];
  logic [S_W-1:0]    s_r   [ROOT_W];
  logic [ROOT_W-1:0] d_r   [ROOT_W];
  logic [DSQ_W-1:0]  dsq_r [ROOT_W];
  root_tag_t         tag_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;

    logic              v_in;
    logic [S_W-1:0]    s_in;
    logic [ROOT_W-1:0] d_in;
    logic [DSQ_W-1:0]  dsq_in;
    root_tag_t         tag_in;
    logic [S_W:0]      cand_sq;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign s_in   = in_s;
      assign d_in   = '0;
      assign dsq_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign s_in   = s_r[k-1];
      assign d_in   = d_r[k-1];
      assign dsq_in = dsq_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    // (d + 2^B)^2 = d^2 + d*2^(B+1) + 2^(2B)
    assign cand_sq = {1'b0, dsq_in} + ((S_W + 1)'(d_in) << (B + 1))
                   + ((S_W + 1)'(1) << (2 * B));
    assign take    = cand_sq <= {1'b0, s_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      s_r[k]   <= s_in;
      tag_r[k] <= tag_in;
      if (take) begin
        d_r[k]   <= d_in | (ROOT_W'(1) << B);
        dsq_r[k] <= cand_sq[DSQ_W-1:0];
      end else begin
        d_r[k]   <= d_in;
        dsq_r[k] <= dsq_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_d     = d_r[ROOT_W-1];
  assign out_dsq   = dsq_r[ROOT_W-1];
  assign out_tag   = tag_r[ROOT_W-1];

endmodule

// ===== hw/rtl/gpf_div.sv =====
// ----------------------------------------------------------------------------
// gpf_div
// Pipelined restoring divider for three numerators over one shared divisor,
// one quotient bit per stage, with an up-front overflow check.
// ----------------------------------------------------------------------------
module gpf_div
  import gpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]      in_den,
  input  div_tag_t              in_tag,
  output logic                  out_valid,
  output logic [2:0][Q_W-1:0]   out_q,
  output logic [2:0]            out_ovf,
  output div_tag_t              out_tag
);

  localparam int NST = Q_W + 1;

  logic                  v_r   [NST];
  logic [2:0][DIV_W-1:0] rem_r [NST];
  logic [2:0][Q_W-1:0]   q_r   [NST];
  logic [2:0]            ovf_r [NST];
  logic [DEN_W-1:0]      den_r [NST];
  div_tag_t              tag_r [NST];

  // Overflow check: quotient would need more than Q_W bits
  logic [DIV_W-1:0] den_top;
  logic [2:0]       ovf0;
  assign den_top = DIV_W'(in_den) << Q_W;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ovf0[c] = DIV_W'(in_num[c]) >= den_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      rem_r[0][c] <= DIV_W'(in_num[c]);
    end
    q_r[0]   <= '0;
    ovf_r[0] <= ovf0;
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
  end

  // Quotient bit stages, most significant first
  for (genvar k = 1; k < NST; k++) begin : g_stage
    localparam int B = Q_W - k;

    logic [DIV_W-1:0]      dsh;
    logic [2:0][DIV_W-1:0] rem_nxt;
    logic [2:0][Q_W-1:0]   q_nxt;

    assign dsh = DIV_W'(den_r[k-1]) << B;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (rem_r[k-1][c] >= dsh) begin
          rem_nxt[c] = rem_r[k-1][c] - dsh;
          q_nxt[c]   = q_r[k-1][c] | (Q_W'(1) << B);
        end else begin
          rem_nxt[c] = rem_r[k-1][c];
          q_nxt[c]   = q_r[k-1][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      q_r[k]   <= q_nxt;
      ovf_r[k] <= ovf_r[k-1];
      den_r[k] <= den_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_q     = q_r[NST-1];
  assign out_ovf   = ovf_r[NST-1];
  assign out_tag   = tag_r[NST-1];

endmodule

// ===== hw/rtl/gravity_pair_force.sv =====
// ----------------------------------------------------------------------------
// gravity_pair_force
// Newtonian pull of a second body on a first: G*mp*delta/d^3 per axis.
//
// A request is taken on any clock edge with start high; busy is always low,
// so one request may enter every cycle. Each result appears on the out_
// ports for exactly one cycle with out_valid high, in request order.
// A request passes the offset, square and numerator product registers,
// then ROOT_W stages of square root (one bit each), two of cube, Q_W + 1
// divider stages (overflow check plus one quotient bit each) and the
// output register.
// Throughput is one request per cycle.
// grav_coeff is written through the APB port (address 0, reset value 1)
// and should only change while no request is in flight.
// Reset clears all valid bits and returns grav_coeff to 1; data in flight
// is discarded.
// The receiver cannot stall the pipeline, so no backpressure exists.
// ----------------------------------------------------------------------------
module gravity_pair_force
  import gpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [POS_BITS-1:0]  in_self_pos_x,
  input  logic [POS_BITS-1:0]  in_self_pos_y,
  input  logic [POS_BITS-1:0]  in_self_pos_z,
  input  logic [POS_BITS-1:0]  in_other_pos_x,
  input  logic [POS_BITS-1:0]  in_other_pos_y,
  input  logic [POS_BITS-1:0]  in_other_pos_z,
  input  logic [MASS_BITS-1:0] in_self_mass,
  input  logic [MASS_BITS-1:0] in_other_mass,
  // result channel
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_pull_x,
  output logic [OUT_W-1:0]     out_pull_y,
  output logic [OUT_W-1:0]     out_pull_z,
  output logic                 out_coincident,
  output logic                 out_saturated,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // --------------------------------------------------------------------------
  // Configuration register (word address decode)
  // --------------------------------------------------------------------------
  logic [G_W-1:0] grav_r;
  logic           sel_grav;

  assign sel_grav = paddr[ADDR_W-1:2] == REG_GRAV_COEFF[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else if (psel && penable && pwrite && sel_grav) begin
      grav_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_grav ? grav_r : 32'd0;
  assign busy   = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: offsets, magnitudes, mass product
  // --------------------------------------------------------------------------
  logic [2:0][POS_BITS-1:0] self_p, other_p;
  logic [2:0][POS_BITS:0]   dif;
  logic [2:0][MAG_W-1:0]    mag1_nxt;
  logic [2:0]               neg1_nxt;

  assign self_p  = {in_self_pos_z, in_self_pos_y, in_self_pos_x};
  assign other_p = {in_other_pos_z, in_other_pos_y, in_other_pos_x};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dif[c]      = {other_p[c][POS_BITS-1], other_p[c]}
                  - {self_p[c][POS_BITS-1], self_p[c]};
      neg1_nxt[c] = dif[c][POS_BITS];
      mag1_nxt[c] = neg1_nxt[c] ? MAG_W'(~dif[c] + 1'b1) : MAG_W'(dif[c]);
    end
  end

  logic                  v1_r;
  logic [2:0][MAG_W-1:0] mag1_r;
  logic [2:0]            neg1_r;
  logic [MP_W-1:0]       mp1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r <= mag1_nxt;
    neg1_r <= neg1_nxt;
    mp1_r  <= in_mode ? MP_W'(in_other_mass)
                      : MP_W'(in_self_mass) * MP_W'(in_other_mass);
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and coefficient partial products
  // --------------------------------------------------------------------------
  logic                        v2_r;
  logic [2:0][SQ_W-1:0]        sq2_r;
  logic [2:0][MAG_W-1:0]       mag2_r;
  logic [2:0]                  neg2_r;
  logic [G_W+MASS_BITS-1:0]    gmlo2_r, gmhi2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq2_r[c] <= SQ_W'(mag1_r[c]) * SQ_W'(mag1_r[c]);
    end
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    gmlo2_r <= (G_W + MASS_BITS)'(grav_r) * (G_W + MASS_BITS)'(mp1_r[MASS_BITS-1:0]);
    gmhi2_r <= (G_W + MASS_BITS)'(grav_r) * (G_W + MASS_BITS)'(mp1_r[MP_W-1:MASS_BITS]);
  end

  // --------------------------------------------------------------------------
  // Stage 3: squared distance, G * mp
  // --------------------------------------------------------------------------
  logic                  v3_r;
  logic [S_W-1:0]        s3_r;
  logic [GM_W-1:0]       gm3_r;
  logic [2:0][MAG_W-1:0] mag3_r;
  logic [2:0]            neg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r   <= S_W'(sq2_r[0]) + S_W'(sq2_r[1]) + S_W'(sq2_r[2]);
    gm3_r  <= GM_W'(gmlo2_r) + (GM_W'(gmhi2_r) << MASS_BITS);
    mag3_r <= mag2_r;
    neg3_r <= neg2_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: G*mp*|delta| partial products
  // --------------------------------------------------------------------------
  logic [N_PIECE*PIECE_W-1:0] gm_pad;
  assign gm_pad = (N_PIECE * PIECE_W)'(gm3_r);

  logic                             v4_r;
  logic [2:0][N_PIECE-1:0][PP_W-1:0] pp4_r;
  logic [S_W-1:0]                   s4_r;
  logic [2:0]                       neg4_r;
  logic                             zero4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < N_PIECE; j++) begin
        pp4_r[c][j] <= PP_W'(gm_pad[j*PIECE_W +: PIECE_W]) * PP_W'(mag3_r[c]);
      end
    end
    s4_r    <= s3_r;
    neg4_r  <= neg3_r;
    zero4_r <= s3_r == '0;
  end

  // --------------------------------------------------------------------------
  // Stage 5: numerators
  // --------------------------------------------------------------------------
  logic [2:0][NUM_W-1:0] num5_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num5_nxt[c] = '0;
      for (int j = 0; j < N_PIECE; j++) begin
        num5_nxt[c] = num5_nxt[c] + (NUM_W'(pp4_r[c][j]) << (j * PIECE_W));
      end
    end
  end

  logic           v5_r;
  logic [S_W-1:0] s5_r;
  root_tag_t      tag5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_r        <= s4_r;
    tag5_r.num  <= num5_nxt;
    tag5_r.neg  <= neg4_r;
    tag5_r.zero <= zero4_r;
  end

  // --------------------------------------------------------------------------
  // Square root pipeline
  // --------------------------------------------------------------------------
  logic              rv;
  logic [ROOT_W-1:0] rd;
  logic [DSQ_W-1:0]  rdsq;
  root_tag_t         rtag;

  gpf_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_s      (s5_r),
    .in_tag    (tag5_r),
    .out_valid (rv),
    .out_d     (rd),
    .out_dsq   (rdsq),
    .out_tag   (rtag)
  );

  // --------------------------------------------------------------------------
  // Cube stages: d^3 from two partial products, then scale
  // --------------------------------------------------------------------------
  logic                  vc1_r;
  logic [DSQ_W-1:0]      pa_r, pb_r;
  root_tag_t             tagc1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0;
    end else begin
      vc1_r <= rv;
    end
  end

  always_ff @(posedge clk) begin
    pa_r    <= DSQ_W'(rdsq[ROOT_W-1:0]) * DSQ_W'(rd);
    pb_r    <= DSQ_W'(rdsq[DSQ_W-1:ROOT_W]) * DSQ_W'(rd);
    tagc1_r <= rtag;
  end

  logic [CUBE_W-1:0] cube;
  assign cube = (CUBE_W'(pb_r) << ROOT_W) + CUBE_W'(pa_r);

  logic                  vc2_r;
  logic [DEN_W-1:0]      den_r;
  logic [2:0][NUM_W-1:0] numc2_r;
  div_tag_t              tagc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc2_r <= 1'b0;
    end else begin
      vc2_r <= vc1_r;
    end
  end

  always_ff @(posedge clk) begin
    den_r        <= DEN_W'(cube) << FRAC_BITS;
    numc2_r      <= tagc1_r.num;
    tagc2_r.neg  <= tagc1_r.neg;
    tagc2_r.zero <= tagc1_r.zero;
  end

  // --------------------------------------------------------------------------
  // Divider pipeline
  // --------------------------------------------------------------------------
  logic                dv;
  logic [2:0][Q_W-1:0] dq;
  logic [2:0]          dovf;
  div_tag_t            dtag;

  gpf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc2_r),
    .in_num    (numc2_r),
    .in_den    (den_r),
    .in_tag    (tagc2_r),
    .out_valid (dv),
    .out_q     (dq),
    .out_ovf   (dovf),
    .out_tag   (dtag)
  );

  // --------------------------------------------------------------------------
  // Sign, saturation and output register
  // --------------------------------------------------------------------------
  logic [2:0][OUT_W-1:0] pull_nxt;
  logic                  sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (dtag.neg[c]) begin
        if (dovf[c] || dq[c] > NEG_LIM) begin
          pull_nxt[c] = OUT_W'(~NEG_LIM + 1'b1);
          sat_nxt     = 1'b1;
        end else begin
          pull_nxt[c] = OUT_W'(~dq[c] + 1'b1);
        end
      end else begin
        if (dovf[c] || dq[c] > POS_LIM) begin
          pull_nxt[c] = OUT_W'(POS_LIM);
          sat_nxt     = 1'b1;
        end else begin
          pull_nxt[c] = OUT_W'(dq[c]);
        end
      end
    end
    // coincident bodies force a zero result
    if (dtag.zero) begin
      pull_nxt = '0;
      sat_nxt  = 1'b0;
    end
  end

  logic                  vo_r;
  logic [2:0][OUT_W-1:0] pull_r;
  logic                  coin_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    pull_r <= pull_nxt;
    coin_r <= dtag.zero;
    sat_r  <= sat_nxt;
  end

  assign out_valid      = vo_r;
  assign out_pull_x     = pull_r[0];
  assign out_pull_y     = pull_r[1];
  assign out_pull_z     = pull_r[2];
  assign out_coincident = coin_r;
  assign out_saturated  = sat_r;

endmodule
